/* rtl/core/pcp_pkg.sv */
package pcp_pkg;

   localparam int UNIT_ONE = 16384;
   localparam logic signed [15:0] DIR_Y_FLOOR = 16'sd164;
   localparam logic [15:0] PAGE_HEIGHT_RESET = 16'd1024;
   localparam logic [43:0] FAR_SCALE = 44'd1310720;   // 20 page heights in Q16.16
   localparam logic [30:0] LEN_CAP = 31'h7FFF_FFFF;
   localparam logic signed [47:0] ZERO_DIV_QUOT = 48'sh0100_0000_0000;
   // 0.45 = 9 / 20; divide by 4 with a shift, then by 5 as ceil(2^36 / 5) and >> 36
   localparam logic [33:0] HEIGHT_RECIP = 34'd13743895348;

   localparam logic [1:0] STATUS_CURVED = 2'd0;
   localparam logic [1:0] STATUS_FLAT   = 2'd1;
   localparam logic [1:0] STATUS_DEGEN  = 2'd2;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] drag_x;
      logic signed [31:0] drag_y;
   } req_type;

   typedef struct packed {
      logic signed [15:0] cos_angle;
      logic signed [15:0] sin_angle;
      logic signed [31:0] adjusted_drag_y;
      logic signed [31:0] shift_x;
      logic signed [31:0] shift_y;
      logic signed [31:0] vanish_y;
      logic signed [31:0] curve_end;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic [30:0]        bend_height;
      logic [30:0]        drag_length;
      logic [1:0]         status;
   } rsp_type;

   // working record carried down the pipeline
   typedef struct packed {
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [15:0] ux;
      logic signed [15:0] uy;
      logic signed [47:0] pv;
      logic signed [41:0] v;
      logic               flat;
      logic               degen;
      logic               vgt;
      logic signed [47:0] q;
      logic [30:0]        lo;
      logic [30:0]        lc;
      logic signed [63:0] pce;
      logic [61:0]        lo2;
      logic [61:0]        lc2;
      logic signed [48:0] ce;
      logic signed [62:0] diff;
      logic signed [42:0] ov;
      logic signed [42:0] cv;
      logic signed [15:0] a1;
      logic signed [15:0] b1;
      logic signed [15:0] a2;
      logic signed [15:0] b2;
      logic signed [31:0] dot;
      logic signed [15:0] cs;
      logic signed [15:0] sn;
      logic [29:0]        sq;
      logic signed [63:0] p_csox;
      logic signed [63:0] p_snox;
      logic signed [63:0] p_snov;
      logic signed [63:0] p_csov;
      logic signed [47:0] tx;
      logic signed [47:0] ty;
      logic [35:0]        hn;
   } item_type;

endpackage

/* rtl/core/pcp_div.sv */
// Unsigned restoring divider, one quotient bit per stage.
// Requires num < den * 2**QW.
module pcp_div
   import pcp_pkg::*;
#(
   parameter int NW = 32,
   parameter int DW = 16,
   parameter int QW = 16,
   parameter type PT = logic
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  PT             in_pay,
   output logic          out_valid,
   output logic [QW-1:0] out_quot,
   output PT             out_pay
);

   localparam int CW = (NW > DW + QW) ? NW : DW + QW;

   logic          vld_ff [QW];
   logic [NW-1:0] rem_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [QW];
   PT             pay_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic          vld_cur;
      logic [NW-1:0] rem_cur;
      logic [DW-1:0] den_cur;
      logic [QW-1:0] quo_cur;
      PT             pay_cur;
      logic [CW-1:0] trial;
      logic [CW-1:0] rem_ext;
      logic [NW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      if (k == 0) begin : g_first
         assign vld_cur = in_valid;
         assign rem_cur = in_num;
         assign den_cur = in_den;
         assign quo_cur = '0;
         assign pay_cur = in_pay;
      end else begin : g_next
         assign vld_cur = vld_ff[k-1];
         assign rem_cur = rem_ff[k-1];
         assign den_cur = den_ff[k-1];
         assign quo_cur = quo_ff[k-1];
         assign pay_cur = pay_ff[k-1];
      end

      // trial subtract of the shifted divisor
      always_comb begin
         trial   = CW'(den_cur) << (QW - 1 - k);
         rem_ext = CW'(rem_cur);
         rem_in  = rem_cur;
         quo_in  = quo_cur;
         if (rem_ext >= trial) begin
            rem_in = NW'(rem_ext - trial);
            quo_in[QW-1-k] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_cur;
         end
         rem_ff[k] <= rem_in;
         den_ff[k] <= den_cur;
         quo_ff[k] <= quo_in;
         pay_ff[k] <= pay_cur;
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quot  = quo_ff[QW-1];
   assign out_pay   = pay_ff[QW-1];

endmodule

/* rtl/core/pcp_sqrt.sv */
// Floor integer square root, one root bit per stage.
module pcp_sqrt
   import pcp_pkg::*;
#(
   parameter int RW = 16,
   parameter type PT = logic
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [2*RW-1:0] in_rad,
   input  PT               in_pay,
   output logic            out_valid,
   output logic [RW-1:0]   out_root,
   output PT               out_pay
);

   localparam int CW = 2 * RW + 1;

   logic            vld_ff  [RW];
   logic [2*RW-1:0] rem_ff  [RW];
   logic [RW-1:0]   root_ff [RW];
   PT               pay_ff  [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic            vld_cur;
      logic [2*RW-1:0] rem_cur;
      logic [RW-1:0]   root_cur;
      PT               pay_cur;
      logic [CW-1:0]   trial;
      logic [2*RW-1:0] rem_in;
      logic [RW-1:0]   root_in;

      if (k == 0) begin : g_first
         assign vld_cur  = in_valid;
         assign rem_cur  = in_rad;
         assign root_cur = '0;
         assign pay_cur  = in_pay;
      end else begin : g_next
         assign vld_cur  = vld_ff[k-1];
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
         assign pay_cur  = pay_ff[k-1];
      end

      // (r + 2^i)^2 - r^2 = r * 2^(i+1) + 2^(2i)
      always_comb begin
         trial   = (CW'(root_cur) << (RW - k)) + (CW'(1) << (2 * (RW - 1 - k)));
         rem_in  = rem_cur;
         root_in = root_cur;
         if (CW'(rem_cur) >= trial) begin
            rem_in = (2*RW)'(CW'(rem_cur) - trial);
            root_in[RW-1-k] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_cur;
         end
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         pay_ff[k]  <= pay_cur;
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_pay   = pay_ff[RW-1];

endmodule

/* rtl/core/pcp_uvec.sv */
// Unit vector in Q1.14: normalise, square, root, two divisions.
module pcp_uvec
   import pcp_pkg::*;
#(
   parameter int AW = 33,
   parameter type PT = logic
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [AW-1:0] in_a,
   input  logic signed [AW-1:0] in_b,
   input  PT                    in_pay,
   output logic                 out_valid,
   output logic signed [15:0]   out_ua,
   output logic signed [15:0]   out_ub,
   output PT                    out_pay
);

   typedef struct packed {
      PT           pay;
      logic        sa;
      logic        sb;
      logic [30:0] ma;
      logic [30:0] mb;
   } uv_type;

   // stage 1: magnitudes, shifted below 2^31
   logic          n_vld_ff;
   uv_type        n_uv_ff;
   uv_type        n_uv_in;
   logic [AW-1:0] mag_a;
   logic [AW-1:0] mag_b;
   logic [AW-1:0] mag_or;
   int            sh;

   always_comb begin
      mag_a  = in_a[AW-1] ? AW'(-in_a) : AW'(in_a);
      mag_b  = in_b[AW-1] ? AW'(-in_b) : AW'(in_b);
      mag_or = mag_a | mag_b;
      sh = 0;
      for (int j = 31; j < AW; j++) begin
         if (mag_or[j]) begin
            sh = j - 30;
         end
      end
      n_uv_in.pay = in_pay;
      n_uv_in.sa  = in_a[AW-1];
      n_uv_in.sb  = in_b[AW-1];
      n_uv_in.ma  = 31'(mag_a >> sh);
      n_uv_in.mb  = 31'(mag_b >> sh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_vld_ff <= 1'b0;
      end else begin
         n_vld_ff <= in_valid;
      end
      n_uv_ff <= n_uv_in;
   end

   // stage 2: sum of squares
   logic        s_vld_ff;
   uv_type      s_uv_ff;
   logic [63:0] s_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff <= 1'b0;
      end else begin
         s_vld_ff <= n_vld_ff;
      end
      s_uv_ff  <= n_uv_ff;
      s_sum_ff <= 64'(n_uv_ff.ma) * 64'(n_uv_ff.ma) + 64'(n_uv_ff.mb) * 64'(n_uv_ff.mb);
   end

   logic        r_vld;
   logic [31:0] r_len;
   uv_type      r_uv;

   pcp_sqrt #(.RW(32), .PT(uv_type)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_vld_ff),
      .in_rad    (s_sum_ff),
      .in_pay    (s_uv_ff),
      .out_valid (r_vld),
      .out_root  (r_len),
      .out_pay   (r_uv)
   );

   // rounded quotients part * 16384 / length
   logic [45:0] num_a;
   logic [45:0] num_b;

   assign num_a = (46'(r_uv.ma) << 14) + 46'(r_len >> 1);
   assign num_b = (46'(r_uv.mb) << 14) + 46'(r_len >> 1);

   logic        d_vld;
   logic [14:0] d_qa;
   logic [14:0] d_qb;
   uv_type      d_uv;

   pcp_div #(.NW(46), .DW(32), .QW(15), .PT(uv_type)) u_div_a (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (r_vld),
      .in_num    (num_a),
      .in_den    (r_len),
      .in_pay    (r_uv),
      .out_valid (d_vld),
      .out_quot  (d_qa),
      .out_pay   (d_uv)
   );

   pcp_div #(.NW(46), .DW(32), .QW(15)) u_div_b (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (r_vld),
      .in_num    (num_b),
      .in_den    (r_len),
      .in_pay    (1'b0),
      .out_valid (),
      .out_quot  (d_qb),
      .out_pay   ()
   );

   // output stage: signs, zero vector
   logic               o_vld_ff;
   logic signed [15:0] o_ua_ff;
   logic signed [15:0] o_ub_ff;
   PT                  o_pay_ff;
   logic               zero_vec;

   assign zero_vec = (d_uv.ma == '0) && (d_uv.mb == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else begin
         o_vld_ff <= d_vld;
      end
      o_pay_ff <= d_uv.pay;
      if (zero_vec) begin
         o_ua_ff <= '0;
         o_ub_ff <= '0;
      end else begin
         o_ua_ff <= d_uv.sa ? -16'(d_qa) : 16'(d_qa);
         o_ub_ff <= d_uv.sb ? -16'(d_qb) : 16'(d_qb);
      end
   end

   assign out_valid = o_vld_ff;
   assign out_ua    = o_ua_ff;
   assign out_ub    = o_ub_ff;
   assign out_pay   = o_pay_ff;

endmodule

/* rtl/core/page_curl_parameter_unit_top.sv */
// Channel   Ports                        Transfer
// request   start, busy, req_data        start high and busy low at a clock edge
// result    rsp_valid, rsp_data          rsp_valid high for one cycle, always taken
// register  csr_valid, csr_ready, csr_data  csr_valid and csr_ready both high
//
// Fully pipelined: one point pair accepted every cycle, busy stays low.
// The pipeline is a chain of bit-per-stage square roots and dividers
// (three unit-vector units, three dividers, two roots).
// Reset (synchronous) clears the valid bits and sets page_height to 1024.
// Results cannot be held off, so the pipeline never stalls.
module page_curl_parameter_unit_top
   import pcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   function automatic logic signed [63:0] rnd14(input logic signed [63:0] p);
      logic [63:0] m;
      logic [63:0] r;
      m = p[63] ? 64'(-p) : 64'(p);
      r = (m + 64'd8192) >> 14;
      return p[63] ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] p);
      if (p > 64'sd2147483647) begin
         return 32'h7FFF_FFFF;
      end else if (p < -64'sd2147483648) begin
         return 32'h8000_0000;
      end
      return p[31:0];
   endfunction

   // page height register
   logic [15:0] ph_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PAGE_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         ph_ff <= csr_data;
      end
   end

   // stage A: capture inputs
   logic     a_vld_ff;
   item_type a_it_ff;
   item_type a_it_in;

   always_comb begin
      a_it_in    = '0;
      a_it_in.ox = req_data.origin_x;
      a_it_in.oy = req_data.origin_y;
      a_it_in.cx = req_data.drag_x;
      a_it_in.cy = req_data.drag_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= start && !busy;
      end
      a_it_ff <= a_it_in;
   end

   logic signed [32:0] dx;
   logic signed [32:0] dy;

   assign dx = 33'(a_it_ff.cx) - 33'(a_it_ff.ox);
   assign dy = 33'(a_it_ff.cy) - 33'(a_it_ff.oy);

   // drag direction
   logic               u1_vld;
   logic signed [15:0] u1_ua;
   logic signed [15:0] u1_ub;
   item_type           u1_it;

   pcp_uvec #(.AW(33), .PT(item_type)) u_uvec_dir (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_vld_ff),
      .in_a      (dx),
      .in_b      (dy),
      .in_pay    (a_it_ff),
      .out_valid (u1_vld),
      .out_ua    (u1_ua),
      .out_ub    (u1_ub),
      .out_pay   (u1_it)
   );

   // stage B: y floor, dir_x * origin_x
   logic     b_vld_ff;
   item_type b_it_ff;
   item_type b_it_in;

   always_comb begin
      b_it_in    = u1_it;
      b_it_in.ux = u1_ua;
      b_it_in.uy = u1_ub;
      if (u1_ub > -DIR_Y_FLOOR && u1_ub < DIR_Y_FLOOR) begin
         b_it_in.uy = DIR_Y_FLOOR;
      end
      b_it_in.pv = 48'(u1_ua) * 48'(u1_it.ox);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= u1_vld;
      end
      b_it_ff <= b_it_in;
   end

   logic [46:0] d1_num;
   logic [14:0] d1_den;

   always_comb begin
      d1_den = b_it_ff.uy[15] ? 15'(-b_it_ff.uy) : 15'(b_it_ff.uy);
      d1_num = (b_it_ff.pv[47] ? 47'(-b_it_ff.pv) : 47'(b_it_ff.pv)) + 47'(d1_den >> 1);
   end

   logic        d1_vld;
   logic [38:0] d1_q;
   item_type    d1_it;

   pcp_div #(.NW(47), .DW(15), .QW(39), .PT(item_type)) u_div_vanish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_vld_ff),
      .in_num    (d1_num),
      .in_den    (d1_den),
      .in_pay    (b_it_ff),
      .out_valid (d1_vld),
      .out_quot  (d1_q),
      .out_pay   (d1_it)
   );

   // stage E: vanishing point
   logic     e_vld_ff;
   item_type e_it_ff;
   item_type e_it_in;

   always_comb begin
      e_it_in = d1_it;
      if (d1_it.pv[47] ^ d1_it.uy[15]) begin
         e_it_in.v = 42'(d1_it.oy) - 42'(d1_q);
      end else begin
         e_it_in.v = 42'(d1_it.oy) + 42'(d1_q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= d1_vld;
      end
      e_it_ff <= e_it_in;
   end

   // stage F: mode test, flat direction
   logic     f_vld_ff;
   item_type f_it_ff;
   item_type f_it_in;
   logic signed [43:0] mid;
   logic signed [43:0] thr;
   logic signed [43:0] dv;
   logic signed [43:0] ndv;

   always_comb begin
      f_it_in = e_it_ff;
      mid = $signed(44'(ph_ff) << 15);
      thr = $signed(44'(ph_ff) * FAR_SCALE);
      dv  = 44'(e_it_ff.v) - mid;
      ndv = -dv;
      f_it_in.flat  = (dv >= thr) || (ndv >= thr);
      f_it_in.vgt   = 44'(e_it_ff.v) > mid;
      f_it_in.degen = 1'b0;
      if (f_it_in.flat) begin
         f_it_in.ux = -16'sd16384;
         f_it_in.uy = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= e_vld_ff;
      end
      f_it_ff <= f_it_in;
   end

   // drag and origin x over dir_x
   logic [14:0] au;
   logic [45:0] d2_num;
   logic [45:0] d3_num;

   always_comb begin
      au = f_it_ff.ux[15] ? 15'(-f_it_ff.ux) : 15'(f_it_ff.ux);
      d2_num = ((f_it_ff.cx[31] ? 46'(-f_it_ff.cx) : 46'(f_it_ff.cx)) << 14) + 46'(au >> 1);
      d3_num = ((f_it_ff.ox[31] ? 46'(-f_it_ff.ox) : 46'(f_it_ff.ox)) << 14) + 46'(au >> 1);
   end

   logic        d2_vld;
   logic [45:0] d2_q;
   logic [45:0] d3_q;
   item_type    d2_it;

   pcp_div #(.NW(46), .DW(15), .QW(46), .PT(item_type)) u_div_drag (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_vld_ff),
      .in_num    (d2_num),
      .in_den    (au),
      .in_pay    (f_it_ff),
      .out_valid (d2_vld),
      .out_quot  (d2_q),
      .out_pay   (d2_it)
   );

   pcp_div #(.NW(46), .DW(15), .QW(46)) u_div_origin (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_vld_ff),
      .in_num    (d3_num),
      .in_den    (au),
      .in_pay    (1'b0),
      .out_valid (),
      .out_quot  (d3_q),
      .out_pay   ()
   );

   // stage G: signed quotient, capped lengths, zero divisor
   logic     g_vld_ff;
   item_type g_it_ff;
   item_type g_it_in;

   always_comb begin
      g_it_in = d2_it;
      if (d2_it.ux == '0) begin
         g_it_in.q     = d2_it.cx[31] ? -ZERO_DIV_QUOT : ZERO_DIV_QUOT;
         g_it_in.lo    = LEN_CAP;
         g_it_in.lc    = LEN_CAP;
         g_it_in.degen = 1'b1;
      end else begin
         g_it_in.q  = (d2_it.cx[31] ^ d2_it.ux[15]) ? -48'(d2_q) : 48'(d2_q);
         g_it_in.lo = (d3_q > 46'(LEN_CAP)) ? LEN_CAP : d3_q[30:0];
         g_it_in.lc = (d2_q > 46'(LEN_CAP)) ? LEN_CAP : d2_q[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else begin
         g_vld_ff <= d2_vld;
      end
      g_it_ff <= g_it_in;
   end

   // stage H: products
   logic     h_vld_ff;
   item_type h_it_ff;
   item_type h_it_in;

   always_comb begin
      h_it_in     = g_it_ff;
      h_it_in.pce = 64'(g_it_ff.uy) * 64'(g_it_ff.q);
      h_it_in.lo2 = 62'(g_it_ff.lo) * 62'(g_it_ff.lo);
      h_it_in.lc2 = 62'(g_it_ff.lc) * 62'(g_it_ff.lc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff <= 1'b0;
      end else begin
         h_vld_ff <= g_vld_ff;
      end
      h_it_ff <= h_it_in;
   end

   // stage I: curve end, length difference, offsets from V
   logic     i_vld_ff;
   item_type i_it_ff;
   item_type i_it_in;

   always_comb begin
      i_it_in      = h_it_ff;
      i_it_in.ce   = 49'(h_it_ff.cy) - 49'(rnd14(h_it_ff.pce));
      i_it_in.diff = $signed({1'b0, h_it_ff.lo2}) - $signed({1'b0, h_it_ff.lc2});
      if (i_it_in.diff[62]) begin
         i_it_in.degen = 1'b1;
      end
      i_it_in.ov = 43'(h_it_ff.oy) - 43'(h_it_ff.v);
      i_it_in.cv = 43'(h_it_ff.cy) - 43'(h_it_ff.v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_vld_ff <= 1'b0;
      end else begin
         i_vld_ff <= h_vld_ff;
      end
      i_it_ff <= i_it_in;
   end

   // unit vectors from V to both centres
   logic               u2_vld;
   logic signed [15:0] u2_ua;
   logic signed [15:0] u2_ub;
   logic signed [15:0] u3_ua;
   logic signed [15:0] u3_ub;
   item_type           u2_it;

   pcp_uvec #(.AW(43), .PT(item_type)) u_uvec_drag (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (i_vld_ff),
      .in_a      (43'(i_it_ff.cx)),
      .in_b      (i_it_ff.cv),
      .in_pay    (i_it_ff),
      .out_valid (u2_vld),
      .out_ua    (u2_ua),
      .out_ub    (u2_ub),
      .out_pay   (u2_it)
   );

   pcp_uvec #(.AW(43)) u_uvec_origin (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (i_vld_ff),
      .in_a      (43'(i_it_ff.ox)),
      .in_b      (i_it_ff.ov),
      .in_pay    (1'b0),
      .out_valid (),
      .out_ua    (u3_ua),
      .out_ub    (u3_ub),
      .out_pay   ()
   );

   // stage J: dot product
   logic     j_vld_ff;
   item_type j_it_ff;
   item_type j_it_in;

   always_comb begin
      j_it_in     = u2_it;
      j_it_in.a1  = u2_ua;
      j_it_in.b1  = u2_ub;
      j_it_in.a2  = u3_ua;
      j_it_in.b2  = u3_ub;
      j_it_in.dot = 32'(u2_ua) * 32'(u3_ua) + 32'(u2_ub) * 32'(u3_ub);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_vld_ff <= 1'b0;
      end else begin
         j_vld_ff <= u2_vld;
      end
      j_it_ff <= j_it_in;
   end

   // stage K: cosine, clamped
   logic     k_vld_ff;
   item_type k_it_ff;
   item_type k_it_in;
   logic signed [63:0] cos_raw;

   always_comb begin
      k_it_in = j_it_ff;
      cos_raw = rnd14(64'(j_it_ff.dot));
      if (cos_raw > 64'sd16384) begin
         k_it_in.cs = 16'sd16384;
      end else if (cos_raw < -64'sd16384) begin
         k_it_in.cs = -16'sd16384;
      end else begin
         k_it_in.cs = cos_raw[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_vld_ff <= 1'b0;
      end else begin
         k_vld_ff <= j_vld_ff;
      end
      k_it_ff <= k_it_in;
   end

   // stage L: 1 - cos^2
   logic     l_vld_ff;
   item_type l_it_ff;
   item_type l_it_in;
   logic signed [31:0] cos_sq;

   always_comb begin
      l_it_in    = k_it_ff;
      cos_sq     = 32'(k_it_ff.cs) * 32'(k_it_ff.cs);
      l_it_in.sq = 30'(32'(UNIT_ONE * UNIT_ONE) - cos_sq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l_vld_ff <= 1'b0;
      end else begin
         l_vld_ff <= k_vld_ff;
      end
      l_it_ff <= l_it_in;
   end

   logic        s1_vld;
   logic [14:0] s1_root;
   item_type    s1_it;

   pcp_sqrt #(.RW(15), .PT(item_type)) u_sqrt_sin (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (l_vld_ff),
      .in_rad    (l_it_ff.sq),
      .in_pay    (l_it_ff),
      .out_valid (s1_vld),
      .out_root  (s1_root),
      .out_pay   (s1_it)
   );

   // stage M: sine sign, rotation products
   logic     m_vld_ff;
   item_type m_it_ff;
   item_type m_it_in;

   always_comb begin
      m_it_in        = s1_it;
      m_it_in.sn     = s1_it.vgt ? 16'(s1_root) : -16'(s1_root);
      m_it_in.p_csox = 64'(s1_it.cs) * 64'(s1_it.ox);
      m_it_in.p_snox = 64'(m_it_in.sn) * 64'(s1_it.ox);
      m_it_in.p_snov = 64'(m_it_in.sn) * 64'(s1_it.ov);
      m_it_in.p_csov = 64'(s1_it.cs) * 64'(s1_it.ov);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else begin
         m_vld_ff <= s1_vld;
      end
      m_it_ff <= m_it_in;
   end

   // stage N: translation, flat mode overrides
   logic     n_vld_ff;
   item_type n_it_ff;
   item_type n_it_in;

   always_comb begin
      n_it_in    = m_it_ff;
      n_it_in.tx = 48'(m_it_ff.cx) - 48'(rnd14(m_it_ff.p_csox)) - 48'(rnd14(m_it_ff.p_snov));
      n_it_in.ty = 48'(m_it_ff.cy) + 48'(rnd14(m_it_ff.p_snox)) - 48'(rnd14(m_it_ff.p_csov));
      if (m_it_ff.flat) begin
         n_it_in.cs = 16'sd16384;
         n_it_in.sn = '0;
         n_it_in.ce = 49'(m_it_ff.oy);
         n_it_in.cy = m_it_ff.oy;
         n_it_in.tx = 48'(m_it_ff.cx) - 48'(m_it_ff.ox);
         n_it_in.ty = 48'(m_it_ff.v);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_vld_ff <= 1'b0;
      end else begin
         n_vld_ff <= m_vld_ff;
      end
      n_it_ff <= n_it_in;
   end

   // bend height root, negative difference gives zero
   logic [61:0] s2_rad;

   assign s2_rad = n_it_ff.diff[62] ? '0 : n_it_ff.diff[61:0];

   logic        s2_vld;
   logic [30:0] s2_root;
   item_type    s2_it;

   pcp_sqrt #(.RW(31), .PT(item_type)) u_sqrt_height (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (n_vld_ff),
      .in_rad    (s2_rad),
      .in_pay    (n_it_ff),
      .out_valid (s2_vld),
      .out_root  (s2_root),
      .out_pay   (s2_it)
   );

   // stage O: root * 9 + 10
   logic     o_vld_ff;
   item_type o_it_ff;
   item_type o_it_in;

   always_comb begin
      o_it_in    = s2_it;
      o_it_in.hn = 36'(s2_root) * 36'd9 + 36'd10;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else begin
         o_vld_ff <= s2_vld;
      end
      o_it_ff <= o_it_in;
   end

   // stage P: quarter of the numerator times the reciprocal of 5, in two halves
   logic        p_vld_ff;
   item_type    p_it_ff;
   logic [50:0] p_lo_ff;
   logic [50:0] p_hi_ff;
   logic [33:0] hq;

   assign hq = o_it_ff.hn[35:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else begin
         p_vld_ff <= o_vld_ff;
      end
      p_it_ff <= o_it_ff;
      p_lo_ff <= 51'(hq[16:0]) * 51'(HEIGHT_RECIP);
      p_hi_ff <= 51'(hq[33:17]) * 51'(HEIGHT_RECIP);
   end

   // halves joined, quotient taken from the top
   logic [67:0] h_prod;
   logic        d4_vld;
   logic [30:0] d4_q;
   item_type    d4_it;

   assign h_prod = 68'(p_lo_ff) + (68'(p_hi_ff) << 17);
   assign d4_vld = p_vld_ff;
   assign d4_q   = h_prod[66:36];
   assign d4_it  = p_it_ff;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   always_comb begin
      rsp_data_in.cos_angle       = d4_it.cs;
      rsp_data_in.sin_angle       = d4_it.sn;
      rsp_data_in.adjusted_drag_y = d4_it.cy;
      rsp_data_in.shift_x         = sat32(64'(d4_it.tx));
      rsp_data_in.shift_y         = sat32(64'(d4_it.ty));
      rsp_data_in.vanish_y        = sat32(64'(d4_it.v));
      rsp_data_in.curve_end       = sat32(64'(d4_it.ce));
      rsp_data_in.dir_x           = d4_it.ux;
      rsp_data_in.dir_y           = d4_it.uy;
      rsp_data_in.bend_height     = d4_q;
      rsp_data_in.drag_length     = d4_it.lc;
      if (d4_it.degen) begin
         rsp_data_in.status = STATUS_DEGEN;
      end else if (d4_it.flat) begin
         rsp_data_in.status = STATUS_FLAT;
      end else begin
         rsp_data_in.status = STATUS_CURVED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= d4_vld;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* tb/sv/page_curl_parameter_unit_top_tb.sv */
`timescale 1ns / 1ps

module page_curl_parameter_unit_top_tb;
   import pcp_pkg::*;

   localparam longint ONE_Q14 = 16384;
   localparam longint CAP_LEN = 64'h7FFF_FFFF;
   localparam int PIPE_DRAIN = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   req_type     pending_points[$];
   rsp_type     expected_curls[$];
   logic [15:0] page_height_shadow = PAGE_HEIGHT_RESET;
   int          errors = 0;
   int          burst_left = 0;
   int          gap_left = 0;

   page_curl_parameter_unit_top dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // fixed-point helpers
   function automatic longint unsigned mag(input longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   function automatic longint div_nearest(input longint n, input longint d);
      longint unsigned an, ad, q;
      an = mag(n);
      ad = mag(d);
      q = (an + ad / 2) / ad;
      return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic void unit_direction(input longint a, input longint b,
                                          output longint ua, output longint ub);
      longint unsigned ma, mb, len;
      ma = mag(a);
      mb = mag(b);
      while (ma >= 64'h8000_0000 || mb >= 64'h8000_0000) begin
         ma = ma >> 1;
         mb = mb >> 1;
      end
      len = floor_root(ma * ma + mb * mb);
      if (len == 0) begin
         ua = 0;
         ub = 0;
         return;
      end
      ma = (ma * ONE_Q14 + len / 2) / len;
      mb = (mb * ONE_Q14 + len / 2) / len;
      ua = (a < 0) ? -longint'(ma) : longint'(ma);
      ub = (b < 0) ? -longint'(mb) : longint'(mb);
   endfunction

   // curl parameters for one point pair at the given page height
   function automatic rsp_type curl_params(input req_type p, input logic [15:0] ph);
      rsp_type e;
      longint ox, oy, cx, cy, ux, uy, v, mid, thr, dv;
      longint cs, sn, tx, ty, ce, ady, lo, lc, diff, h, q, a1, b1, a2, b2;
      longint unsigned au, qo, qc;
      bit degen, flat;
      ox = p.origin_x;
      oy = p.origin_y;
      cx = p.drag_x;
      cy = p.drag_y;
      degen = 1'b0;
      unit_direction(cx - ox, cy - oy, ux, uy);
      if (uy > -longint'(DIR_Y_FLOOR) && uy < longint'(DIR_Y_FLOOR)) uy = DIR_Y_FLOOR;
      v = oy + div_nearest(ux * ox, uy);
      mid = longint'(ph) * 32768;
      thr = longint'(ph) * 20 * 65536;
      dv = v - mid;
      flat = (dv >= thr) || (-dv >= thr);
      if (flat) begin
         ux = -ONE_Q14;
         uy = 0;
         ady = oy;
         ce = oy;
         cs = ONE_Q14;
         sn = 0;
         tx = cx - ox;
         ty = v;
      end else begin
         ady = cy;
         if (ux == 0) begin
            q = (cx >= 0) ? (64'sd1 <<< 40) : -(64'sd1 <<< 40);
            degen = 1'b1;
         end else begin
            q = div_nearest(cx * ONE_Q14, ux);
         end
         ce = cy - div_nearest(uy * q, ONE_Q14);
         unit_direction(cx, cy - v, a1, b1);
         unit_direction(ox, oy - v, a2, b2);
         cs = div_nearest(a1 * a2 + b1 * b2, ONE_Q14);
         if (cs > ONE_Q14) cs = ONE_Q14;
         if (cs < -ONE_Q14) cs = -ONE_Q14;
         sn = longint'(floor_root(ONE_Q14 * ONE_Q14 - cs * cs));
         if (!(v > mid)) sn = -sn;
         tx = cx - div_nearest(cs * ox, ONE_Q14) - div_nearest(sn * (oy - v), ONE_Q14);
         ty = cy + div_nearest(sn * ox, ONE_Q14) - div_nearest(cs * (oy - v), ONE_Q14);
      end
      // lengths along the direction
      if (ux == 0) begin
         lo = CAP_LEN;
         lc = CAP_LEN;
         degen = 1'b1;
      end else begin
         au = mag(ux);
         qo = (mag(ox) * ONE_Q14 + au / 2) / au;
         qc = (mag(cx) * ONE_Q14 + au / 2) / au;
         lo = (qo > CAP_LEN) ? CAP_LEN : longint'(qo);
         lc = (qc > CAP_LEN) ? CAP_LEN : longint'(qc);
      end
      diff = lo * lo - lc * lc;
      if (diff < 0) begin
         h = 0;
         degen = 1'b1;
      end else begin
         h = longint'((floor_root(diff) * 9 + 10) / 20);
      end
      e.cos_angle = cs[15:0];
      e.sin_angle = sn[15:0];
      e.adjusted_drag_y = ady[31:0];
      e.shift_x = 32'(clip32(tx));
      e.shift_y = 32'(clip32(ty));
      e.vanish_y = 32'(clip32(v));
      e.curve_end = 32'(clip32(ce));
      e.dir_x = ux[15:0];
      e.dir_y = uy[15:0];
      e.bend_height = h[30:0];
      e.drag_length = lc[30:0];
      e.status = degen ? STATUS_DEGEN : (flat ? STATUS_FLAT : STATUS_CURVED);
      return e;
   endfunction

   function automatic void check_field(input string name, input longint exp_v,
                                       input longint act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v, act_v);
         errors++;
      end
   endfunction

   // request driver: bursts and gaps, changes at the falling edge
   always @(negedge clock) begin
      if (reset || pending_points.size() == 0) begin
         start <= 1'b0;
      end else if (gap_left > 0) begin
         start <= 1'b0;
         gap_left--;
      end else begin
         start <= 1'b1;
         req_data <= pending_points[0];
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 8);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         end
      end
   end

   // request transfer and result check at the rising edge
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && start && !busy) begin
         expected_curls.push_back(curl_params(req_data, page_height_shadow));
         void'(pending_points.pop_front());
      end
      if (!reset && rsp_valid) begin
         if (expected_curls.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %h", $realtime, rsp_data);
            errors++;
         end else begin
            e = expected_curls.pop_front();
            check_field("cos_angle", e.cos_angle, rsp_data.cos_angle);
            check_field("sin_angle", e.sin_angle, rsp_data.sin_angle);
            check_field("adjusted_drag_y", e.adjusted_drag_y, rsp_data.adjusted_drag_y);
            check_field("shift_x", e.shift_x, rsp_data.shift_x);
            check_field("shift_y", e.shift_y, rsp_data.shift_y);
            check_field("vanish_y", e.vanish_y, rsp_data.vanish_y);
            check_field("curve_end", e.curve_end, rsp_data.curve_end);
            check_field("dir_x", e.dir_x, rsp_data.dir_x);
            check_field("dir_y", e.dir_y, rsp_data.dir_y);
            check_field("bend_height", e.bend_height, rsp_data.bend_height);
            check_field("drag_length", e.drag_length, rsp_data.drag_length);
            check_field("status", e.status, rsp_data.status);
         end
      end
   end

   function automatic logic signed [31:0] rand_coord(input logic [15:0] ph);
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return int'($urandom) >>> $urandom_range(0, 31);
         2: return int'($urandom_range(0, 2 * ph + 2)) <<< 16;
         3: return int'($urandom_range(0, 65535)) - int'($urandom_range(0, 65535)) * 65536;
         default: return int'($urandom_range(0, 4 * ph + 4)) * 65536 + $urandom_range(0, 65535);
      endcase
   endfunction

   function automatic req_type rand_points(input logic [15:0] ph);
      req_type p;
      p.origin_x = rand_coord(ph);
      p.origin_y = rand_coord(ph);
      p.drag_x = rand_coord(ph);
      p.drag_y = rand_coord(ph);
      case ($urandom_range(0, 15))
         0, 1: p.drag_x = p.origin_x;
         2: p = '{p.origin_x, p.origin_y, p.origin_x, p.origin_y};
         3: p.drag_y = p.origin_y + $urandom_range(0, 3) - 1;
         4: p.drag_x = (p.origin_x >>> 2);
         default: ;
      endcase
      return p;
   endfunction

   task automatic wait_idle();
      while (pending_points.size() != 0 || expected_curls.size() != 0) @(negedge clock);
      repeat (PIPE_DRAIN) @(negedge clock);
   endtask

   task automatic write_page_height(input logic [15:0] ph);
      csr_valid <= 1'b1;
      csr_data <= ph;
      do @(posedge clock); while (!csr_ready);
      page_height_shadow = ph;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stimulus: directed corners, then random phases over several page heights
   initial begin
      logic [15:0] heights[6];
      heights = '{16'd1024, 16'd1, 16'd65535, 16'd7, 16'd0, 16'd512};
      heights[3] = $urandom_range(2, 4000);
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // corners: zero, extremes, vertical and horizontal drags, zero vector
      pending_points.push_back('{32'sd0, 32'sd0, 32'sd0, 32'sd0});
      pending_points.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000});
      pending_points.push_back('{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
      pending_points.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000});
      pending_points.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001});
      pending_points.push_back('{32'd600 << 16, 32'd500 << 16, 32'd600 << 16, 32'd100 << 16});
      pending_points.push_back('{32'd600 << 16, 32'd500 << 16, 32'd200 << 16, 32'd500 << 16});
      pending_points.push_back('{32'd600 << 16, 32'd500 << 16, 32'd200 << 16, 32'd501 << 16});
      pending_points.push_back('{32'd600 << 16, 32'd500 << 16, 32'd200 << 16, 32'd499 << 16});
      pending_points.push_back('{32'd600 << 16, 32'd700 << 16, 32'd300 << 16, 32'd400 << 16});
      pending_points.push_back('{32'd600 << 16, 32'd300 << 16, 32'd300 << 16, 32'd600 << 16});
      pending_points.push_back('{32'd100 << 16, 32'd300 << 16, 32'd900 << 16, 32'd600 << 16});
      pending_points.push_back('{-32'sd600 <<< 16, 32'd300 << 16, 32'd300 << 16, 32'd310 << 16});
      pending_points.push_back('{32'd600 << 16, 32'd512 << 16, 32'd590 << 16, 32'd512 << 16});
      pending_points.push_back('{32'd600 << 16, 32'd512 << 16, 32'd590 << 16, 32'd900 << 16});
      pending_points.push_back('{32'd600 << 16, 32'd512 << 16, 32'd600 << 16, 32'd512 << 16});
      pending_points.push_back('{32'sd0, 32'd512 << 16, 32'd10 << 16, 32'd400 << 16});
      pending_points.push_back('{32'h4000_0000, 32'hC000_0000, 32'h3FFF_0000, 32'hC000_1000});
      for (int ph_i = 0; ph_i < 6; ph_i++) begin
         wait_idle();
         write_page_height(heights[ph_i]);
         repeat (110) pending_points.push_back(rand_points(heights[ph_i]));
      end
      wait_idle();
      if (errors == 0) begin
         $display("[page_curl_parameter_unit_top] OK");
      end else begin
         $display("[page_curl_parameter_unit_top] ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("[page_curl_parameter_unit_top] ERROR");
      $finish;
   end

endmodule

/* files.f */
rtl/core/pcp_pkg.sv
rtl/core/pcp_div.sv
rtl/core/pcp_sqrt.sv
rtl/core/pcp_uvec.sv
rtl/core/page_curl_parameter_unit_top.sv
tb/sv/page_curl_parameter_unit_top_tb.sv
